>>> hw/rtl/c5x5_pkg.sv
`timescale 1ns / 1ps
package c5x5_pkg;
   localparam int IMAGE_SIZE_DEF  = 28;
   localparam int KERNEL_SIZE_DEF = 5;
   localparam int CHANNELS_DEF    = 6;
   localparam int MAX_CH          = 6;
   localparam int SUM_W           = 40;
   localparam int ACC_W           = 48;
   localparam int POS_W           = 5;

   localparam logic [1:0] CMD_WEIGHT = 2'd0;
   localparam logic [1:0] CMD_BIAS   = 2'd1;
   localparam logic [1:0] CMD_PIXEL  = 2'd2;
   localparam logic [1:0] CMD_RSVD   = 2'd3;

   typedef struct packed {
      logic read;
      logic mac;
      logic finish;
   } ctl_type;

   typedef struct packed {
      logic read_done;
      logic emits;
      logic last_tap;
   } sts_type;

   function automatic logic signed [SUM_W-1:0] sat40(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = {{(ACC_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
      lo = ~hi;
      if (v > hi) sat40 = hi[SUM_W-1:0];
      else if (v < lo) sat40 = lo[SUM_W-1:0];
      else sat40 = v[SUM_W-1:0];
   endfunction
endpackage

>>> hw/rtl/c5x5_if.sv
`timescale 1ns / 1ps
interface c5x5_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        command;
   logic [7:0]        load_index;
   logic signed [15:0] data_value;
   modport source (output valid, command, load_index, data_value, input ready);
   modport sink (input valid, command, load_index, data_value, output ready);
endinterface

interface c5x5_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [39:0] sum_ch0;
   logic signed [39:0] sum_ch1;
   logic signed [39:0] sum_ch2;
   logic signed [39:0] sum_ch3;
   logic signed [39:0] sum_ch4;
   logic signed [39:0] sum_ch5;
   logic [4:0]         out_row;
   logic [4:0]         out_col;
   logic               frame_last;
   modport source (output valid, sum_ch0, sum_ch1, sum_ch2, sum_ch3, sum_ch4, sum_ch5,
                   out_row, out_col, frame_last, input ready);
   modport sink (input valid, sum_ch0, sum_ch1, sum_ch2, sum_ch3, sum_ch4, sum_ch5,
                 out_row, out_col, frame_last, output ready);
endinterface

>>> hw/rtl/c5x5_ram.sv
`timescale 1ns / 1ps
module c5x5_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 112
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

>>> hw/rtl/c5x5_ctrl.sv
`timescale 1ns / 1ps
module c5x5_ctrl import c5x5_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    go,
   input  logic    rsp_ready,
   input  sts_type sts,
   output ctl_type ctl,
   output logic    busy,
   output logic    rsp_valid
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_MAC  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_ready;
      ctl = '0;
      unique case (state_ff)
         S_IDLE: if (go) state_in = S_READ;
         S_READ: begin
            ctl.read = 1'b1;
            // pixels that do not complete a window end here
            if (sts.read_done) state_in = sts.emits ? S_MAC : S_IDLE;
         end
         S_MAC: begin
            ctl.mac = 1'b1;
            if (sts.last_tap) state_in = S_DONE;
         end
         S_DONE: if (!valid_ff || rsp_ready) begin
            ctl.finish = 1'b1;
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy = state_ff != S_IDLE;
   assign rsp_valid = valid_ff;
endmodule

>>> hw/rtl/c5x5_dp.sv
`timescale 1ns / 1ps
module c5x5_dp import c5x5_pkg::*; #(
   parameter int IMAGE_SIZE  = IMAGE_SIZE_DEF,
   parameter int KERNEL_SIZE = KERNEL_SIZE_DEF,
   parameter int CHANNELS    = CHANNELS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               acc_item,
   input  logic [1:0]         command,
   input  logic [7:0]         load_index,
   input  logic signed [15:0] data_value,
   input  ctl_type            ctl,
   output sts_type            sts,
   output logic               go,
   output logic signed [SUM_W-1:0] sums [MAX_CH],
   output logic [POS_W-1:0]   out_row,
   output logic [POS_W-1:0]   out_col,
   output logic               frame_last
);
   localparam int K      = KERNEL_SIZE;
   localparam int TAPS   = K * K;
   localparam int SROWS  = K - 1;
   localparam int DEPTH  = SROWS * IMAGE_SIZE;
   localparam int AW     = $clog2(DEPTH);
   localparam int PW     = $clog2(IMAGE_SIZE);
   localparam int SW     = (SROWS > 1) ? $clog2(SROWS) : 1;
   localparam int TW     = $clog2(TAPS);
   localparam int KW     = $clog2(K);

   logic signed [15:0] wts_ff [MAX_CH][TAPS];
   logic signed [15:0] bias_ff [MAX_CH];
   logic signed [15:0] win_ff [K][K];
   logic signed [ACC_W-1:0] acc_ff [MAX_CH];
   logic signed [31:0] prod [MAX_CH];
   logic [PW-1:0] row_ff, col_ff, r_ff, c_ff;
   logic [SW-1:0] slot_ff, base_ff, rslot_ff;
   logic signed [15:0] pix_ff;
   logic [KW-1:0] rd_k_ff, tr_ff, tc_ff;
   logic [TW-1:0] tap_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [15:0]   rd_data;
   logic          last_pix;

   c5x5_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(pix_ff),
      .rd_addr(rd_addr), .rd_data(rd_data));

   // the first read hits the slot being written; registered read returns the old entry
   assign rd_addr = AW'(32'(rslot_ff) * IMAGE_SIZE + 32'(c_ff));
   assign wr_en   = ctl.read && rd_k_ff == '0;
   assign wr_addr = AW'(32'(base_ff) * IMAGE_SIZE + 32'(c_ff));
   assign last_pix = (r_ff == PW'(IMAGE_SIZE - 1)) && (c_ff == PW'(IMAGE_SIZE - 1));

   assign go = acc_item && command == CMD_PIXEL;
   assign sts.read_done = rd_k_ff == KW'(K - 1);
   assign sts.emits = (32'(r_ff) >= K - 1) && (32'(c_ff) >= K - 1);
   assign sts.last_tap = tap_ff == TW'(TAPS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < MAX_CH; ch++) begin
            for (int t = 0; t < TAPS; t++) wts_ff[ch][t] <= '0;
            bias_ff[ch] <= '0;
         end
         row_ff <= '0;
         col_ff <= '0;
         slot_ff <= '0;
      end else begin
         if (acc_item && command == CMD_WEIGHT)
            for (int ch = 0; ch < CHANNELS; ch++)
               if (32'(load_index) >= ch * TAPS && 32'(load_index) < (ch + 1) * TAPS)
                  wts_ff[ch][TW'(32'(load_index) - ch * TAPS)] <= data_value;
         if (acc_item && command == CMD_BIAS)
            for (int ch = 0; ch < CHANNELS; ch++)
               if (32'(load_index) == ch) bias_ff[ch] <= data_value;
         if (go) begin
            if (col_ff == PW'(IMAGE_SIZE - 1)) begin
               col_ff <= '0;
               if (row_ff == PW'(IMAGE_SIZE - 1)) begin
                  row_ff <= '0;
                  slot_ff <= '0;
               end else begin
                  row_ff <= row_ff + 1'b1;
                  slot_ff <= (slot_ff == SW'(SROWS - 1)) ? '0 : slot_ff + 1'b1;
               end
            end else col_ff <= col_ff + 1'b1;
         end
      end
   end

   // store reads: slot (r+kr) mod (K-1) for kr = 0..K-2; the registered read data fills window row kr
   always_ff @(posedge clock) begin
      if (go) begin
         r_ff <= row_ff;
         c_ff <= col_ff;
         pix_ff <= data_value;
         base_ff <= slot_ff;
         rslot_ff <= slot_ff;
         rd_k_ff <= '0;
         for (int kr = 0; kr < K; kr++)
            for (int kc = 0; kc < K - 1; kc++) win_ff[kr][kc] <= win_ff[kr][kc+1];
         win_ff[K-1][K-1] <= data_value;
      end else if (ctl.read) begin
         rslot_ff <= (rslot_ff == SW'(SROWS - 1)) ? '0 : rslot_ff + 1'b1;
         rd_k_ff <= rd_k_ff + 1'b1;
         if (rd_k_ff != '0) win_ff[rd_k_ff - 1'b1][K-1] <= rd_data;
      end
   end

   always_comb begin
      for (int ch = 0; ch < MAX_CH; ch++) prod[ch] = wts_ff[ch][tap_ff] * win_ff[tr_ff][tc_ff];
   end

   always_ff @(posedge clock) begin
      if (ctl.read) begin
         tap_ff <= '0;
         tr_ff <= '0;
         tc_ff <= '0;
         for (int ch = 0; ch < MAX_CH; ch++) acc_ff[ch] <= ACC_W'(bias_ff[ch]) <<< 12;
      end else if (ctl.mac) begin
         for (int ch = 0; ch < MAX_CH; ch++) acc_ff[ch] <= acc_ff[ch] + ACC_W'(prod[ch]);
         tap_ff <= tap_ff + 1'b1;
         if (tc_ff == KW'(K - 1)) begin
            tc_ff <= '0;
            tr_ff <= tr_ff + 1'b1;
         end else tc_ff <= tc_ff + 1'b1;
      end
   end

   // absent channels keep zero weights and bias, so they saturate to zero
   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         for (int ch = 0; ch < MAX_CH; ch++) sums[ch] <= sat40(acc_ff[ch]);
         out_row <= POS_W'(32'(r_ff) - (K - 1));
         out_col <= POS_W'(32'(c_ff) - (K - 1));
         frame_last <= last_pix;
      end
   end
endmodule

>>> hw/rtl/conv5x5_six_channel_forward_unit.sv
`timescale 1ns / 1ps
// 5x5 valid convolution over a streamed square image, six output channels.
// Weight and bias loads are stored on acceptance. A pixel that does not complete
// a window goes through acceptance, then the line-store reads, and ends there.
// A pixel that completes a window goes through acceptance and the store reads,
// then one kernel tap per cycle on six parallel channel multipliers, then
// saturation into the result register. A result still waiting holds the next
// window pixel in its last step.
module conv5x5_six_channel_forward_unit import c5x5_pkg::*; #(
   parameter int IMAGE_SIZE  = IMAGE_SIZE_DEF,
   parameter int KERNEL_SIZE = KERNEL_SIZE_DEF,
   parameter int CHANNELS    = CHANNELS_DEF
) (
   input logic clock,
   input logic reset,
   c5x5_req_if.sink   req,
   c5x5_rsp_if.source rsp
);
   ctl_type ctl;
   sts_type sts;
   logic busy, go, acc_item;
   logic signed [SUM_W-1:0] sums [MAX_CH];

   assign req.ready = !busy;
   assign acc_item  = req.valid && req.ready;

   c5x5_ctrl u_ctrl (
      .clock(clock), .reset(reset), .go(go), .rsp_ready(rsp.ready),
      .sts(sts), .ctl(ctl), .busy(busy), .rsp_valid(rsp.valid));

   c5x5_dp #(.IMAGE_SIZE(IMAGE_SIZE), .KERNEL_SIZE(KERNEL_SIZE), .CHANNELS(CHANNELS)) u_dp (
      .clock(clock), .reset(reset), .acc_item(acc_item), .command(req.command),
      .load_index(req.load_index), .data_value(req.data_value), .ctl(ctl), .sts(sts),
      .go(go), .sums(sums), .out_row(rsp.out_row), .out_col(rsp.out_col),
      .frame_last(rsp.frame_last));

   assign rsp.sum_ch0 = sums[0];
   assign rsp.sum_ch1 = sums[1];
   assign rsp.sum_ch2 = sums[2];
   assign rsp.sum_ch3 = sums[3];
   assign rsp.sum_ch4 = sums[4];
   assign rsp.sum_ch5 = sums[5];
endmodule
